@@ design/pcm_sample_player_16ch_macros.svh @@
// Assertion macros for the sample player checker.
`ifndef PCM_SAMPLE_PLAYER_16CH_MACROS_SVH
`define PCM_SAMPLE_PLAYER_16CH_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define PSP_ASSERT_IMPL(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");
// Implication checked in the cycle after the antecedent.
`define PSP_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");
`endif

@@ design/psp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psp_pkg
// Types, constants and the pan curve of the sample player.
// ----------------------------------------------------------------------------
package psp_pkg;
   localparam int CHANNELS = 16;
   localparam int STORE_ADDR_BITS = 20;
   localparam int CH_BITS = 4;
   localparam int PITCH_BITS = 20;

   localparam logic [1:0] OP_BUS = 2'd0;
   localparam logic [1:0] OP_TICK = 2'd1;
   localparam logic [1:0] OP_LOAD = 2'd2;

   localparam logic [1:0] PORT_HIGH = 2'd0;
   localparam logic [1:0] PORT_LOW = 2'd1;
   localparam logic [1:0] PORT_CMD = 2'd2;

   localparam logic [2:0] REG_BANK = 3'd0;
   localparam logic [2:0] REG_ADDR = 3'd1;
   localparam logic [2:0] REG_PITCH = 3'd2;
   localparam logic [2:0] REG_LOOP = 3'd4;
   localparam logic [2:0] REG_END = 3'd5;
   localparam logic [2:0] REG_VOL = 3'd6;

   localparam logic [7:0] CODE_PAN = 8'h80;
   localparam logic [7:0] CODE_NONE = 8'h90;

   // One channel record as it sits in the channel memory.
   typedef struct packed {
      logic [6:0]  bank;
      logic [16:0] address;
      logic [19:0] pitch;
      logic [15:0] loop_len;
      logic [15:0] end_point;
      logic [15:0] volume;
      logic        keyed;
      logic [8:0]  left_gain;
      logic [8:0]  right_gain;
      logic [7:0]  last_sample;
      logic [20:0] phase;
   } chan_type;

   localparam int CHAN_BITS = $bits(chan_type);

   typedef enum logic [3:0] {
      ST_IDLE, ST_CMD_RD, ST_CMD_WR, ST_TK_RD, ST_TK_CALC, ST_TK_MOD, ST_TK_FETCH,
      ST_TK_MUL, ST_TK_SUM, ST_CLEAR, ST_DONE
   } state_type;

   function automatic logic [8:0] pan_value(input logic [5:0] i);
      logic [8:0] v;
      unique case (i)
         6'd0: v = 9'd0;     6'd1: v = 9'd45;   6'd2: v = 9'd64;   6'd3: v = 9'd78;
         6'd4: v = 9'd90;    6'd5: v = 9'd101;  6'd6: v = 9'd110;  6'd7: v = 9'd119;
         6'd8: v = 9'd128;   6'd9: v = 9'd135;  6'd10: v = 9'd143; 6'd11: v = 9'd150;
         6'd12: v = 9'd156;  6'd13: v = 9'd163; 6'd14: v = 9'd169; 6'd15: v = 9'd175;
         6'd16: v = 9'd181;  6'd17: v = 9'd186; 6'd18: v = 9'd192; 6'd19: v = 9'd197;
         6'd20: v = 9'd202;  6'd21: v = 9'd207; 6'd22: v = 9'd212; 6'd23: v = 9'd217;
         6'd24: v = 9'd221;  6'd25: v = 9'd226; 6'd26: v = 9'd230; 6'd27: v = 9'd235;
         6'd28: v = 9'd239;  6'd29: v = 9'd243; 6'd30: v = 9'd247; 6'd31: v = 9'd251;
         default: v = 9'd256;
      endcase
      return v;
   endfunction
endpackage
`default_nettype wire

@@ design/psp_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psp_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module psp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]              rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

@@ design/psp_modulo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psp_modulo
// Restoring remainder unit: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psp_modulo (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [22:0] dividend,
   input  wire logic [20:0] divisor,
   output logic             done,
   output logic [20:0]      remainder
);
   logic [22:0] rem_ff, rem_in;
   logic [22:0] quo_ff, quo_in;
   logic [4:0]  count_ff, count_in;
   logic        run_ff, run_in;
   logic [23:0] trial;

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      count_in = count_ff;
      run_in = run_ff;
      trial = {rem_ff, quo_ff[22]} - {3'd0, divisor};
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         count_in = 5'd23;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!trial[23]) begin
            rem_in = trial[22:0];
         end else begin
            rem_in = {rem_ff[21:0], quo_ff[22]};
         end
         quo_in = {quo_ff[21:0], 1'b0};
         count_in = count_ff - 5'd1;
         if (count_ff == 5'd1) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         run_ff <= run_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done = run_ff && (count_ff == 5'd1);
   assign remainder = rem_in[20:0];
endmodule
`default_nettype wire

@@ design/pcm_sample_player_16ch.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcm_sample_player_16ch
// Sixteen-channel 8-bit PCM player with per-channel records in RAM.
// ----------------------------------------------------------------------------
// Channel   Handshake            Beat
// req       start / busy         op, port, bytes, store load
// rsp       rsp_valid strobe     left and right sums
// csr       APB, pready high     rom_length at address 0
//
// A latch write, an ignored beat or a store load holds busy for one cycle; a
// command reads and then rewrites one channel record. A tick visits each channel:
// one that does not step is read, computed, multiplied and accumulated; one that
// fetches also runs the remainder unit and a store read between compute and
// multiply. A final state carries the result strobe. After reset a clear pass
// clears the channel RAM while busy is high. Results cannot be stalled.
module pcm_sample_player_16ch (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_op,
   input  wire logic [1:0]         req_port_offset,
   input  wire logic [7:0]         req_bus_byte,
   input  wire logic [19:0]        req_rom_address,
   input  wire logic signed [7:0]  req_rom_byte,
   output logic                    rsp_valid,
   output logic signed [22:0]      rsp_left_sum,
   output logic signed [22:0]      rsp_right_sum,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [2:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);
   localparam int AB = psp_pkg::STORE_ADDR_BITS;

   psp_pkg::state_type state_ff, state_in;
   logic [20:0] rom_len_ff;
   logic [15:0] latch_ff, latch_in;
   logic [7:0]  code_ff;
   logic        load_ff;
   logic [psp_pkg::CH_BITS-1:0] ch_ff, ch_in;
   psp_pkg::chan_type rec_ff, rec_in;
   logic signed [22:0] left_ff, left_in, right_ff, right_in;
   logic signed [16:0] lg_ff, rg_ff;
   logic signed [23:0] pl_ff, pr_ff;
   logic        fetch_ff, fetch_in;
   logic        contrib_ff, contrib_in;
   logic [AB-1:0] load_addr_ff;
   logic [7:0]  load_byte_ff;

   psp_pkg::chan_type chan_rd, chan_wr;
   logic chan_we;
   logic [psp_pkg::CH_BITS-1:0] chan_addr;
   logic [7:0] store_rd;
   logic store_we;
   logic [AB-1:0] store_addr, fetch_addr_ff;
   logic mod_start, mod_done;
   logic [20:0] mod_rem;
   logic [22:0] mod_num;
   logic [20:0] mod_den;

   psp_ram #(.WIDTH(psp_pkg::CHAN_BITS), .DEPTH(psp_pkg::CHANNELS)) u_chan_ram (
      .clock(clock), .wr_en(chan_we), .addr(chan_addr), .wr_data(chan_wr),
      .rd_data(chan_rd));
   psp_ram #(.WIDTH(8), .DEPTH(1 << AB)) u_store_ram (
      .clock(clock), .wr_en(store_we), .addr(store_addr), .wr_data(load_byte_ff),
      .rd_data(store_rd));
   psp_modulo u_mod (
      .clock(clock), .reset(reset), .start(mod_start), .dividend(mod_num),
      .divisor(mod_den), .done(mod_done), .remainder(mod_rem));

   assign pready = 1'b1;
   assign prdata = (paddr == 3'd0) ? {11'd0, rom_len_ff} : 32'd0;
   // The remainder unit is started from CALC, where rec_in holds the new address.
   assign mod_num = {rec_in.bank, 16'd0} + {6'd0, rec_in.address};
   assign mod_den = (rom_len_ff == 21'd0) ? 21'h100000 : rom_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_len_ff <= 21'h100000;
      end else if (psel && penable && pwrite && paddr == 3'd0) begin
         rom_len_ff <= pwdata[20:0];
      end
   end

   // Decoded command target.
   logic [2:0] cmd_reg;
   logic       cmd_pan, cmd_ok;
   logic [psp_pkg::CH_BITS-1:0] cmd_ch;
   logic [5:0] pan_idx, pan_raw;
   always_comb begin
      cmd_pan = (code_ff >= psp_pkg::CODE_PAN) && (code_ff < psp_pkg::CODE_NONE);
      cmd_reg = code_ff[2:0];
      cmd_ok = (code_ff < psp_pkg::CODE_PAN) || cmd_pan;
      if (cmd_pan) begin
         cmd_ch = code_ff[3:0];
      end else if (cmd_reg == psp_pkg::REG_BANK) begin
         cmd_ch = code_ff[6:3] + 4'd1;
      end else begin
         cmd_ch = code_ff[6:3];
      end
      pan_raw = latch_ff[5:0] - 6'h10;
      pan_idx = (pan_raw > 6'd32) ? 6'd32 : pan_raw;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         psp_pkg::ST_IDLE: begin
            if (start) begin
               priority case (req_op)
                  psp_pkg::OP_BUS:
                     state_in = (req_port_offset == psp_pkg::PORT_CMD) ?
                        psp_pkg::ST_CMD_RD : psp_pkg::ST_DONE;
                  psp_pkg::OP_TICK: state_in = psp_pkg::ST_TK_RD;
                  default: state_in = psp_pkg::ST_DONE;
               endcase
            end
         end
         psp_pkg::ST_CMD_RD: state_in = psp_pkg::ST_CMD_WR;
         psp_pkg::ST_CMD_WR: state_in = psp_pkg::ST_DONE;
         psp_pkg::ST_TK_RD: state_in = psp_pkg::ST_TK_CALC;
         psp_pkg::ST_TK_CALC: state_in = fetch_in ? psp_pkg::ST_TK_MOD : psp_pkg::ST_TK_MUL;
         psp_pkg::ST_TK_MOD: state_in = mod_done ? psp_pkg::ST_TK_FETCH : psp_pkg::ST_TK_MOD;
         psp_pkg::ST_TK_FETCH: state_in = psp_pkg::ST_TK_MUL;
         psp_pkg::ST_TK_MUL: state_in = psp_pkg::ST_TK_SUM;
         psp_pkg::ST_TK_SUM: state_in = (ch_ff == 4'(psp_pkg::CHANNELS - 1)) ?
            psp_pkg::ST_DONE : psp_pkg::ST_TK_RD;
         psp_pkg::ST_CLEAR: state_in = (ch_ff == 4'(psp_pkg::CHANNELS - 1)) ?
            psp_pkg::ST_IDLE : psp_pkg::ST_CLEAR;
         psp_pkg::ST_DONE: state_in = psp_pkg::ST_IDLE;
         default: state_in = psp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      latch_in = latch_ff;
      ch_in = ch_ff;
      rec_in = rec_ff;
      left_in = left_ff;
      right_in = right_ff;
      fetch_in = fetch_ff;
      contrib_in = contrib_ff;
      chan_we = 1'b0;
      chan_addr = ch_ff;
      chan_wr = rec_ff;
      store_we = 1'b0;
      store_addr = fetch_addr_ff;
      mod_start = 1'b0;
      busy = (state_ff != psp_pkg::ST_IDLE);
      unique case (state_ff)
         psp_pkg::ST_IDLE: begin
            ch_in = '0;
            left_in = '0;
            right_in = '0;
            if (start && req_op == psp_pkg::OP_BUS) begin
               if (req_port_offset == psp_pkg::PORT_HIGH) latch_in[15:8] = req_bus_byte;
               if (req_port_offset == psp_pkg::PORT_LOW) latch_in[7:0] = req_bus_byte;
            end
         end
         psp_pkg::ST_CMD_RD: begin
            chan_addr = cmd_ch;
         end
         psp_pkg::ST_CMD_WR: begin
            chan_addr = cmd_ch;
            chan_wr = chan_rd;
            chan_we = cmd_ok;
            if (cmd_pan) begin
               chan_wr.right_gain = psp_pkg::pan_value(pan_idx);
               chan_wr.left_gain = psp_pkg::pan_value(6'd32 - pan_idx);
            end else begin
               unique case (cmd_reg)
                  psp_pkg::REG_BANK: chan_wr.bank = latch_ff[6:0];
                  psp_pkg::REG_ADDR: chan_wr.address = {1'b0, latch_ff};
                  psp_pkg::REG_PITCH: begin
                     chan_wr.pitch = {latch_ff, 4'd0};
                     if (latch_ff == 16'd0) chan_wr.keyed = 1'b0;
                  end
                  psp_pkg::REG_LOOP: chan_wr.loop_len = latch_ff;
                  psp_pkg::REG_END: chan_wr.end_point = latch_ff;
                  psp_pkg::REG_VOL: begin
                     if (latch_ff == 16'd0) begin
                        chan_wr.keyed = 1'b0;
                     end else if (!chan_rd.keyed) begin
                        chan_wr.keyed = 1'b1;
                        chan_wr.phase = '0;
                        chan_wr.last_sample = '0;
                     end
                     chan_wr.volume = latch_ff;
                  end
                  default: chan_we = 1'b0;
               endcase
            end
         end
         psp_pkg::ST_TK_RD: begin
         end
         psp_pkg::ST_TK_CALC: begin
            rec_in = chan_rd;
            fetch_in = 1'b0;
            contrib_in = chan_rd.keyed;
            if (chan_rd.keyed && chan_rd.phase[20:16] != 5'd0) begin
               rec_in.phase = {5'd0, chan_rd.phase[15:0]};
               rec_in.address = chan_rd.address + {12'd0, chan_rd.phase[20:16]};
               if (rec_in.address >= {1'b0, chan_rd.end_point}) begin
                  if (chan_rd.loop_len == 16'd0) begin
                     rec_in.keyed = 1'b0;
                     contrib_in = 1'b0;
                  end else begin
                     rec_in.address = {1'b0, chan_rd.end_point - chan_rd.loop_len};
                  end
               end
               fetch_in = contrib_in;
            end
            mod_start = fetch_in;
         end
         psp_pkg::ST_TK_MOD: begin
            // Present the reduced address as it appears so the byte is ready in FETCH.
            if (mod_done) store_addr = mod_rem[AB-1:0];
         end
         psp_pkg::ST_TK_FETCH: begin
            rec_in.last_sample = store_rd;
         end
         psp_pkg::ST_TK_MUL: begin
         end
         psp_pkg::ST_TK_SUM: begin
            if (contrib_ff) begin
               left_in = left_ff + 23'(pl_ff >>> 6);
               right_in = right_ff + 23'(pr_ff >>> 6);
               rec_in.phase = rec_ff.phase + {1'b0, rec_ff.pitch};
            end
            chan_wr = rec_in;
            chan_we = 1'b1;
            ch_in = ch_ff + 4'd1;
         end
         psp_pkg::ST_CLEAR: begin
            chan_wr = '0;
            chan_we = 1'b1;
            ch_in = ch_ff + 4'd1;
         end
         psp_pkg::ST_DONE: begin
            store_addr = load_addr_ff;
            store_we = load_ff;
         end
         default: begin
         end
      endcase
   end

   // Gains are taken from the record as it enters the channel pipeline.
   logic [24:0] lgv, rgv;
   assign lgv = rec_in.left_gain * rec_in.volume;
   assign rgv = rec_in.right_gain * rec_in.volume;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= psp_pkg::ST_CLEAR;
         latch_ff <= '0;
         ch_ff <= '0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         latch_ff <= latch_in;
         ch_ff <= ch_in;
         rsp_valid <= (state_ff == psp_pkg::ST_TK_SUM) &&
            (ch_ff == 4'(psp_pkg::CHANNELS - 1));
      end
      rec_ff <= rec_in;
      left_ff <= left_in;
      right_ff <= right_in;
      fetch_ff <= fetch_in;
      contrib_ff <= contrib_in;
      if (state_ff == psp_pkg::ST_IDLE && start) begin
         code_ff <= req_bus_byte;
         load_ff <= (req_op == psp_pkg::OP_LOAD);
         load_addr_ff <= req_rom_address[AB-1:0];
         load_byte_ff <= req_rom_byte;
      end
      if (mod_done) fetch_addr_ff <= mod_rem[AB-1:0];
      // Multiply stage: gains first, then sample times gain.
      if (state_ff == psp_pkg::ST_TK_CALC || state_ff == psp_pkg::ST_TK_MOD ||
          state_ff == psp_pkg::ST_TK_FETCH) begin
         lg_ff <= $signed(lgv[24:8]);
         rg_ff <= $signed(rgv[24:8]);
      end
      if (state_ff == psp_pkg::ST_TK_MUL) begin
         pl_ff <= 24'($signed(rec_ff.last_sample)) * 24'(lg_ff);
         pr_ff <= 24'($signed(rec_ff.last_sample)) * 24'(rg_ff);
      end
      if (state_ff == psp_pkg::ST_TK_SUM) begin
         rsp_left_sum <= left_in;
         rsp_right_sum <= right_in;
      end
   end
endmodule
`default_nettype wire

@@ design/psp_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "pcm_sample_player_16ch_macros.svh"
// ----------------------------------------------------------------------------
// psp_checker
// Port-level checks of the sample player.
// ----------------------------------------------------------------------------
module psp_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic       rsp_valid,
   input wire logic       pready
);
   `PSP_ASSERT_IMPL(a_strobe_single, clock, reset, rsp_valid, !$past(rsp_valid))
   `PSP_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `PSP_ASSERT_NEXT(a_result_then_idle, clock, reset, rsp_valid, !busy)
   `PSP_ASSERT_IMPL(a_ready, clock, reset, 1'b1, pready)
endmodule

bind pcm_sample_player_16ch psp_checker u_psp_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .pready(pready));
`default_nettype wire
